FILE: design/rsnh_pkg.sv
// Shared types, constants and tables for the ray surface nearest hit block.
`timescale 1ns / 1ps
`default_nettype none

package rsnh_pkg;

	// Field widths.
	localparam int COORD_W = 32;
	localparam int ANGLE_W = 19;
	localparam int RADIUS_W = 31;
	localparam int DIST_W = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int COORD_FRAC_BITS_DEF = 16;

	// Angle codes in units of 2^-16 rad.
	localparam logic [ANGLE_W-1:0] ANGLE_MAX_CODE = 19'd411774;
	localparam logic [ANGLE_W-1:0] BELOW_PI_LAST_CODE = 19'd205887;
	localparam logic [ANGLE_W-1:0] VERTICAL_CODE = 19'd102944;

	// Direction vector is Q2.30.
	localparam int DIR_FRAC = 30;
	localparam int DIR_W = 32;
	localparam logic signed [DIR_W-1:0] DIR_ONE = 32'sd1073741824;

	// Rotation CORDIC.
	localparam int CORDIC_STEPS = 28;
	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_INIT = 34'sd652032874;
	localparam logic signed [CW-1:0] PI_Q29 = 34'sd1686629713;
	localparam logic signed [CW-1:0] HALF_PI_Q29 = 34'sd843314857;
	localparam logic signed [CW-1:0] THREE_HALF_PI_Q29 = 34'sd2529944570;
	localparam logic signed [CW-1:0] TWO_PI_Q29 = 34'sd3373259426;
	localparam logic signed [CW-1:0] CLAMP_ONE = 34'sd1073741824;
	localparam logic [29:0] ATAN_Q29 [CORDIC_STEPS] = '{
		30'd421657428, 30'd248918915, 30'd131521918, 30'd66762579, 30'd33510843,
		30'd16771758, 30'd8387925, 30'd4194219, 30'd2097141, 30'd1048575,
		30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768, 30'd16384,
		30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128,
		30'd64, 30'd32, 30'd16, 30'd8, 30'd4
	};

	// Raw distance along the ray and its limits.
	localparam int T_W = 37;
	localparam int MAG_W = 34;
	localparam logic signed [T_W-1:0] T_LIMIT = 37'sd8589934592;

	// Solver sizes and latencies.
	localparam int DIV_STEPS = 33;
	localparam int SQRT_STEPS = 32;
	localparam int DIR_LAT = CORDIC_STEPS + 2;
	localparam int LINE_CORE_LAT = DIV_STEPS + 4;
	localparam int SOLVE_LAT = SQRT_STEPS + 8;
	localparam int PLACE_LAT = 3;
	localparam int TOTAL_LAT = DIR_LAT + SOLVE_LAT + PLACE_LAT + 1;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SURFACE_KIND = 3'd0,
		REG_LINE_A       = 3'd1,
		REG_LINE_B       = 3'd2,
		REG_LINE_C       = 3'd3,
		REG_CENTER_X     = 3'd4,
		REG_CENTER_Y     = 3'd5,
		REG_RADIUS       = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                        surface_kind;
		logic signed [COORD_W-1:0]   line_a;
		logic signed [COORD_W-1:0]   line_b;
		logic signed [COORD_W-1:0]   line_c;
		logic signed [COORD_W-1:0]   center_x;
		logic signed [COORD_W-1:0]   center_y;
		logic        [RADIUS_W-1:0]  radius;
	} cfg_t;

	// Start point, direction and forward sense of one beat.
	typedef struct packed {
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] y0;
		logic signed [DIR_W-1:0]   c;
		logic signed [DIR_W-1:0]   s;
		logic                      upward;
	} ray_t;

	// One placed candidate hit.
	typedef struct packed {
		logic                      ok;
		logic        [MAG_W-1:0]   mag;
		logic        [DIST_W-1:0]  dist_sat;
		logic signed [COORD_W-1:0] hx;
		logic signed [COORD_W-1:0] hy;
	} cand_t;

endpackage

`default_nettype wire

FILE: design/rsnh_dir.sv
// Angle folding and pipelined rotation CORDIC that produce the ray direction.
`timescale 1ns / 1ps
`default_nettype none

module rsnh_dir (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	input  wire logic signed [rsnh_pkg::COORD_W-1:0]   in_x0,
	input  wire logic signed [rsnh_pkg::COORD_W-1:0]   in_y0,
	input  wire logic        [rsnh_pkg::ANGLE_W-1:0]   in_angle,
	output logic                                       out_valid,
	output rsnh_pkg::ray_t                             out_ray
);

	localparam int CW = rsnh_pkg::CW;
	localparam int STEPS = rsnh_pkg::CORDIC_STEPS;

	typedef struct packed {
		logic signed [rsnh_pkg::COORD_W-1:0] x0;
		logic signed [rsnh_pkg::COORD_W-1:0] y0;
		logic                                upward;
		logic                                flip;
		logic                                zero;
		logic                                vert;
	} side_t;

	logic [rsnh_pkg::ANGLE_W-1:0] code_c;
	logic signed [CW-1:0]         z_raw;

	logic                 v_s1;
	side_t                side_s1;
	logic signed [CW-1:0] z_s1;

	logic                 cv_s2 [STEPS];
	side_t                cside_s2 [STEPS];
	logic signed [CW-1:0] cx_s2 [STEPS];
	logic signed [CW-1:0] cy_s2 [STEPS];
	logic signed [CW-1:0] cz_s2 [STEPS];

	logic signed [CW-1:0] xf;
	logic signed [CW-1:0] yf;
	side_t                lside;

	function automatic logic signed [rsnh_pkg::DIR_W-1:0] clamp_dir(
		input logic signed [CW-1:0] v
	);
		logic signed [rsnh_pkg::DIR_W-1:0] r;
		if (v > rsnh_pkg::CLAMP_ONE) begin
			r = rsnh_pkg::DIR_ONE;
		end else if (v < -rsnh_pkg::CLAMP_ONE) begin
			r = -rsnh_pkg::DIR_ONE;
		end else begin
			r = v[rsnh_pkg::DIR_W-1:0];
		end
		return r;
	endfunction

	// Clamp the code and widen it to radians in Q.29.
	always_comb begin
		code_c = (in_angle > rsnh_pkg::ANGLE_MAX_CODE) ? rsnh_pkg::ANGLE_MAX_CODE : in_angle;
		z_raw = $signed({2'b00, code_c, 13'b0});
	end

	// Fold the angle into the CORDIC range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.x0 <= in_x0;
		side_s1.y0 <= in_y0;
		side_s1.upward <= (code_c <= rsnh_pkg::BELOW_PI_LAST_CODE);
		side_s1.zero <= (code_c == '0);
		side_s1.vert <= (code_c == rsnh_pkg::VERTICAL_CODE);
		if (z_raw > rsnh_pkg::THREE_HALF_PI_Q29) begin
			z_s1 <= z_raw - rsnh_pkg::TWO_PI_Q29;
			side_s1.flip <= 1'b0;
		end else if (z_raw > rsnh_pkg::HALF_PI_Q29) begin
			z_s1 <= z_raw - rsnh_pkg::PI_Q29;
			side_s1.flip <= 1'b1;
		end else begin
			z_s1 <= z_raw;
			side_s1.flip <= 1'b0;
		end
	end

	// One rotation step per stage.
	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		logic                 vi;
		side_t                si;
		logic signed [CW-1:0] xi;
		logic signed [CW-1:0] yi;
		logic signed [CW-1:0] zi;
		logic signed [CW-1:0] ai;

		if (i == 0) begin : g_first
			assign vi = v_s1;
			assign si = side_s1;
			assign xi = rsnh_pkg::CORDIC_INIT;
			assign yi = '0;
			assign zi = z_s1;
		end else begin : g_next
			assign vi = cv_s2[i-1];
			assign si = cside_s2[i-1];
			assign xi = cx_s2[i-1];
			assign yi = cy_s2[i-1];
			assign zi = cz_s2[i-1];
		end

		assign ai = $signed({{(CW-30){1'b0}}, rsnh_pkg::ATAN_Q29[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s2[i] <= 1'b0;
			end else begin
				cv_s2[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			cside_s2[i] <= si;
			if (zi >= 0) begin
				cx_s2[i] <= xi - (yi >>> i);
				cy_s2[i] <= yi + (xi >>> i);
				cz_s2[i] <= zi - ai;
			end else begin
				cx_s2[i] <= xi + (yi >>> i);
				cy_s2[i] <= yi - (xi >>> i);
				cz_s2[i] <= zi + ai;
			end
		end
	end

	// Undo the fold, clamp, and apply the exact horizontal and vertical directions.
	always_comb begin
		lside = cside_s2[STEPS-1];
		xf = lside.flip ? -cx_s2[STEPS-1] : cx_s2[STEPS-1];
		yf = lside.flip ? -cy_s2[STEPS-1] : cy_s2[STEPS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= cv_s2[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		out_ray.x0 <= lside.x0;
		out_ray.y0 <= lside.y0;
		out_ray.upward <= lside.upward;
		if (lside.zero) begin
			out_ray.c <= rsnh_pkg::DIR_ONE;
			out_ray.s <= '0;
		end else if (lside.vert) begin
			out_ray.c <= '0;
			out_ray.s <= rsnh_pkg::DIR_ONE;
		end else begin
			out_ray.c <= clamp_dir(xf);
			out_ray.s <= clamp_dir(yf);
		end
	end

endmodule

`default_nettype wire

FILE: design/rsnh_line.sv
// Line solver: plane equation terms and a pipelined restoring divider for t.
`timescale 1ns / 1ps
`default_nettype none

module rsnh_line #(
	parameter int COORD_FRAC_BITS = rsnh_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire rsnh_pkg::ray_t                       in_ray,
	input  wire rsnh_pkg::cfg_t                       cfg,
	output logic signed [rsnh_pkg::T_W-1:0]           out_t,
	output logic                                      out_ok
);

	localparam int STEPS = rsnh_pkg::DIV_STEPS;
	localparam int INT_STEPS = 3;
	localparam int RW = 66;
	localparam int PAD = rsnh_pkg::SOLVE_LAT - rsnh_pkg::LINE_CORE_LAT;

	logic signed [63:0] c_ext;

	logic signed [63:0] pa_s1, pb_s1, pc_s1, da_s1, db_s1;
	logic signed [65:0] n_s2;
	logic signed [63:0] d_s2;
	logic [63:0]        nmag_s3;
	logic [62:0]        dmag_s3;
	logic               nneg_s3, dneg_s3;
	logic [63:0]        nabs;
	logic [63:0]        dabs;

	logic [RW-1:0]      rem_s4 [STEPS];
	logic [STEPS-1:0]   q_s4 [STEPS];
	logic [62:0]        dmag_s4 [STEPS];
	logic               nneg_s4 [STEPS];
	logic               dneg_s4 [STEPS];
	logic               go_s4 [STEPS];

	logic signed [rsnh_pkg::T_W-1:0] t_s5;
	logic                            ok_s5;
	logic signed [rsnh_pkg::T_W-1:0] t_s6 [PAD];
	logic                            ok_s6 [PAD];

	assign c_ext = {{32{cfg.line_c[31]}}, cfg.line_c};

	// Products of the plane equation and of the direction.
	always_ff @(posedge clk) begin
		pa_s1 <= $signed(cfg.line_a) * $signed(in_ray.x0);
		pb_s1 <= $signed(cfg.line_b) * $signed(in_ray.y0);
		pc_s1 <= c_ext <<< COORD_FRAC_BITS;
		da_s1 <= $signed(cfg.line_a) * $signed(in_ray.c);
		db_s1 <= $signed(cfg.line_b) * $signed(in_ray.s);
	end

	// Numerator and denominator sums.
	always_ff @(posedge clk) begin
		n_s2 <= {{2{pa_s1[63]}}, pa_s1} + {{2{pb_s1[63]}}, pb_s1} + {{2{pc_s1[63]}}, pc_s1};
		d_s2 <= da_s1 + db_s1;
	end

	// Magnitudes and signs.
	always_comb begin
		nabs = n_s2[65] ? 64'(-n_s2) : n_s2[63:0];
		dabs = d_s2[63] ? -d_s2 : d_s2;
	end

	always_ff @(posedge clk) begin
		nmag_s3 <= nabs;
		dmag_s3 <= dabs[62:0];
		nneg_s3 <= n_s2[65];
		dneg_s3 <= d_s2[63];
	end

	// One quotient bit per stage: three integer bits, then thirty fraction bits.
	for (genvar k = 0; k < STEPS; k++) begin : g_div
		logic [RW-1:0]    rin;
		logic [STEPS-1:0] qin;
		logic [62:0]      dm;
		logic             nn, dn, gin;
		logic [RW-1:0]    rsh;
		logic [RW-1:0]    dsh;
		logic [RW:0]      trial;

		if (k == 0) begin : g_first
			assign rin = {2'b00, nmag_s3};
			assign qin = '0;
			assign dm = dmag_s3;
			assign nn = nneg_s3;
			assign dn = dneg_s3;
			assign gin = ({3'b000, nmag_s3[63:3]} < {3'b000, dmag_s3});
		end else begin : g_next
			assign rin = rem_s4[k-1];
			assign qin = q_s4[k-1];
			assign dm = dmag_s4[k-1];
			assign nn = nneg_s4[k-1];
			assign dn = dneg_s4[k-1];
			assign gin = go_s4[k-1];
		end

		if (k < INT_STEPS) begin : g_int
			assign rsh = rin;
			assign dsh = {3'b000, dm} << (INT_STEPS - 1 - k);
		end else begin : g_frac
			assign rsh = {rin[RW-2:0], 1'b0};
			assign dsh = {3'b000, dm};
		end

		assign trial = {1'b0, rsh} - {1'b0, dsh};

		always_ff @(posedge clk) begin
			rem_s4[k] <= trial[RW] ? rsh : trial[RW-1:0];
			q_s4[k] <= {qin[STEPS-2:0], ~trial[RW]};
			dmag_s4[k] <= dm;
			nneg_s4[k] <= nn;
			dneg_s4[k] <= dn;
			go_s4[k] <= gin;
		end
	end

	// Apply the sign of -N/D.
	always_ff @(posedge clk) begin
		if (nneg_s4[STEPS-1] == dneg_s4[STEPS-1]) begin
			t_s5 <= -$signed({4'b0000, q_s4[STEPS-1]});
		end else begin
			t_s5 <= $signed({4'b0000, q_s4[STEPS-1]});
		end
		ok_s5 <= go_s4[STEPS-1];
	end

	// Align with the circle solver.
	always_ff @(posedge clk) begin
		t_s6[0] <= t_s5;
		ok_s6[0] <= ok_s5;
		for (int k = 1; k < PAD; k++) begin
			t_s6[k] <= t_s6[k-1];
			ok_s6[k] <= ok_s6[k-1];
		end
	end

	assign out_t = t_s6[PAD-1];
	assign out_ok = ok_s6[PAD-1];

endmodule

`default_nettype wire

FILE: design/rsnh_circle.sv
// Circle solver: projections, chord half length by a pipelined square root.
`timescale 1ns / 1ps
`default_nettype none

module rsnh_circle (
	input  wire logic                                 clk,
	input  wire rsnh_pkg::ray_t                       in_ray,
	input  wire rsnh_pkg::cfg_t                       cfg,
	output logic signed [rsnh_pkg::T_W-1:0]           out_t1,
	output logic signed [rsnh_pkg::T_W-1:0]           out_t2,
	output logic                                      out_ok
);

	localparam int T_W = rsnh_pkg::T_W;
	localparam int STEPS = rsnh_pkg::SQRT_STEPS;
	localparam int RB = rsnh_pkg::RADIUS_W;

	logic signed [32:0] u_s1, v_s1;
	logic signed [31:0] c_s1, s_s1;
	logic signed [64:0] uc_s2, vs_s2, us_s2, vc_s2;
	logic signed [65:0] sa_s3, sb_s3;
	logic [64:0]        m1_s4, m2_s4;
	logic               fneg_s4;
	logic signed [T_W-1:0] f_s5;
	logic [34:0]        ap_s5;
	logic               inr_s5;
	logic signed [T_W-1:0] f_s6;
	logic [61:0]        ap2_s6, rr_s6;
	logic               inr_s6;
	logic signed [T_W-1:0] f_s7;
	logic [61:0]        rad_s7;
	logic               inr_s7;
	logic [63:0]        sv_s8 [STEPS];
	logic [63:0]        sr_s8 [STEPS];
	logic signed [T_W-1:0] f_s8 [STEPS];
	logic               inr_s8 [STEPS];
	logic signed [65:0] sa_abs, sb_abs;
	logic signed [T_W-1:0] len_e;

	// Offsets from the center.
	always_ff @(posedge clk) begin
		u_s1 <= {in_ray.x0[31], in_ray.x0} - {cfg.center_x[31], cfg.center_x};
		v_s1 <= {in_ray.y0[31], in_ray.y0} - {cfg.center_y[31], cfg.center_y};
		c_s1 <= in_ray.c;
		s_s1 <= in_ray.s;
	end

	// Projection products.
	always_ff @(posedge clk) begin
		uc_s2 <= u_s1 * c_s1;
		vs_s2 <= v_s1 * s_s1;
		us_s2 <= u_s1 * s_s1;
		vc_s2 <= v_s1 * c_s1;
	end

	// Along-track and cross-track sums.
	always_ff @(posedge clk) begin
		sa_s3 <= {uc_s2[64], uc_s2} + {vs_s2[64], vs_s2};
		sb_s3 <= {us_s2[64], us_s2} - {vc_s2[64], vc_s2};
	end

	// Magnitudes, so that the shift truncates toward zero.
	always_comb begin
		sa_abs = sa_s3[65] ? -sa_s3 : sa_s3;
		sb_abs = sb_s3[65] ? -sb_s3 : sb_s3;
	end

	always_ff @(posedge clk) begin
		m1_s4 <= sa_abs[64:0];
		m2_s4 <= sb_abs[64:0];
		fneg_s4 <= (sa_s3 > 0);
	end

	// Foot of the perpendicular and the miss test.
	always_ff @(posedge clk) begin
		f_s5 <= fneg_s4 ? -$signed({2'b00, m1_s4[64:30]}) : $signed({2'b00, m1_s4[64:30]});
		ap_s5 <= m2_s4[64:30];
		inr_s5 <= (m2_s4[64:30] <= {4'b0000, cfg.radius});
	end

	// Squares of the radius and of the cross-track distance.
	always_ff @(posedge clk) begin
		ap2_s6 <= ap_s5[RB-1:0] * ap_s5[RB-1:0];
		rr_s6 <= cfg.radius * cfg.radius;
		f_s6 <= f_s5;
		inr_s6 <= inr_s5;
	end

	always_ff @(posedge clk) begin
		rad_s7 <= rr_s6 - ap2_s6;
		f_s7 <= f_s6;
		inr_s7 <= inr_s6;
	end

	// Integer square root, one result bit per stage.
	for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
		localparam logic [63:0] BITK = 64'd1 << (62 - 2 * k);
		logic [63:0]         vin, rin;
		logic signed [T_W-1:0] fin;
		logic                iin;
		logic [64:0]         trial;

		if (k == 0) begin : g_first
			assign vin = {2'b00, rad_s7};
			assign rin = '0;
			assign fin = f_s7;
			assign iin = inr_s7;
		end else begin : g_next
			assign vin = sv_s8[k-1];
			assign rin = sr_s8[k-1];
			assign fin = f_s8[k-1];
			assign iin = inr_s8[k-1];
		end

		assign trial = {1'b0, vin} - ({1'b0, rin} + {1'b0, BITK});

		always_ff @(posedge clk) begin
			if (!trial[64]) begin
				sv_s8[k] <= trial[63:0];
				sr_s8[k] <= (rin >> 1) + BITK;
			end else begin
				sv_s8[k] <= vin;
				sr_s8[k] <= rin >> 1;
			end
			f_s8[k] <= fin;
			inr_s8[k] <= iin;
		end
	end

	// The two candidate distances.
	assign len_e = $signed({{(T_W - RB){1'b0}}, sr_s8[STEPS-1][RB-1:0]});

	always_ff @(posedge clk) begin
		out_t1 <= f_s8[STEPS-1] + len_e;
		out_t2 <= f_s8[STEPS-1] - len_e;
		out_ok <= inr_s8[STEPS-1];
	end

endmodule

`default_nettype wire

FILE: design/rsnh_place.sv
// Places one candidate distance on the ray and checks range and forward sense.
`timescale 1ns / 1ps
`default_nettype none

module rsnh_place (
	input  wire logic                                 clk,
	input  wire logic signed [rsnh_pkg::T_W-1:0]      in_t,
	input  wire logic                                 in_ok,
	input  wire rsnh_pkg::ray_t                       in_ray,
	output rsnh_pkg::cand_t                           out_cand
);

	localparam int T_W = rsnh_pkg::T_W;
	localparam int MAG_W = rsnh_pkg::MAG_W;
	localparam int DW = rsnh_pkg::DIST_W;
	localparam logic signed [65:0] ROUND_BIAS = 66'sd1073741823;

	logic signed [T_W-1:0] tabs;
	logic signed [MAG_W-1:0] tn;

	logic                   lim_s1, up_s1;
	logic signed [65:0]     tc_s1, ts_s1;
	logic [MAG_W-1:0]       mag_s1;
	logic signed [31:0]     x0_s1, y0_s1;

	logic signed [65:0]     tcb, tsb;
	logic                   lim_s2, up_s2;
	logic signed [35:0]     dx_s2, dy_s2;
	logic [MAG_W-1:0]       mag_s2;
	logic [DW-1:0]          dist_s2;
	logic signed [31:0]     x0_s2, y0_s2;

	logic signed [36:0]     px, py;
	logic                   fwd;

	assign tabs = in_t[T_W-1] ? -in_t : in_t;
	assign tn = in_t[MAG_W-1:0];

	// Limit check and the scaled offsets.
	always_ff @(posedge clk) begin
		lim_s1 <= in_ok && (in_t < rsnh_pkg::T_LIMIT) && (in_t > -rsnh_pkg::T_LIMIT);
		tc_s1 <= tn * $signed(in_ray.c);
		ts_s1 <= tn * $signed(in_ray.s);
		mag_s1 <= tabs[MAG_W-1:0];
		x0_s1 <= in_ray.x0;
		y0_s1 <= in_ray.y0;
		up_s1 <= in_ray.upward;
	end

	// Divide by 2^30 rounding toward zero.
	always_comb begin
		tcb = tc_s1 + (tc_s1[65] ? ROUND_BIAS : 66'sd0);
		tsb = ts_s1 + (ts_s1[65] ? ROUND_BIAS : 66'sd0);
	end

	always_ff @(posedge clk) begin
		dx_s2 <= tcb[65:30];
		dy_s2 <= tsb[65:30];
		lim_s2 <= lim_s1;
		mag_s2 <= mag_s1;
		dist_s2 <= (mag_s1[MAG_W-1:DW] != '0) ? '1 : mag_s1[DW-1:0];
		x0_s2 <= x0_s1;
		y0_s2 <= y0_s1;
		up_s2 <= up_s1;
	end

	// Hit point, range check and forward test.
	always_comb begin
		px = {{5{x0_s2[31]}}, x0_s2} + {dx_s2[35], dx_s2};
		py = {{5{y0_s2[31]}}, y0_s2} + {dy_s2[35], dy_s2};
		fwd = up_s2 ? (dy_s2 > 0) : (dy_s2 < 0);
	end

	always_ff @(posedge clk) begin
		out_cand.ok <= lim_s2 && fwd
			&& ((px[36:31] == '0) || (px[36:31] == '1))
			&& ((py[36:31] == '0) || (py[36:31] == '1));
		out_cand.mag <= mag_s2;
		out_cand.dist_sat <= dist_s2;
		out_cand.hx <= px[31:0];
		out_cand.hy <= py[31:0];
	end

endmodule

`default_nettype wire

FILE: design/ray_surface_nearest_hit.sv
// Top level of the nearest forward hit of a 2-D ray on a line or a circle.
//
//  Channel   Signals                                     Direction  Beat taken when
//  command   start, busy, start_x, start_y, track_angle  in         start && !busy
//  result    done, hit_found, hit_distance, hit_x, hit_y out        done (one cycle)
//  config    cfg_write, cfg_index, cfg_data              in         cfg_write
//
// A new command beat is taken every cycle; busy is always low.
// The path runs through the direction CORDIC, the square root and divider
// pipelines of the solvers, hit placement and 1 output register.
// Reset clears the valid bits and restores the configuration registers to their defaults.
// There are no stalls: the result is shown for one cycle with done high.
`timescale 1ns / 1ps
`default_nettype none

module ray_surface_nearest_hit #(
	parameter int COORD_FRAC_BITS = rsnh_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic signed [rsnh_pkg::COORD_W-1:0]    start_x,
	input  wire logic signed [rsnh_pkg::COORD_W-1:0]    start_y,
	input  wire logic        [rsnh_pkg::ANGLE_W-1:0]    track_angle,
	output logic                                        done,
	output logic                                        hit_found,
	output logic             [rsnh_pkg::DIST_W-1:0]     hit_distance,
	output logic signed      [rsnh_pkg::COORD_W-1:0]    hit_x,
	output logic signed      [rsnh_pkg::COORD_W-1:0]    hit_y,
	input  wire logic                                   cfg_write,
	input  wire logic        [rsnh_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic        [rsnh_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int SLAT = rsnh_pkg::SOLVE_LAT;
	localparam int VLAT = rsnh_pkg::SOLVE_LAT + rsnh_pkg::PLACE_LAT;

	logic            accept;
	rsnh_pkg::cfg_t  cfg_q;
	logic            dir_valid;
	rsnh_pkg::ray_t  dir_ray;
	rsnh_pkg::ray_t  ray_dl_s1 [SLAT];
	logic            vld_dl_s1 [VLAT];

	logic signed [rsnh_pkg::T_W-1:0] line_t, circ_t1, circ_t2, ta;
	logic            line_ok, circ_ok, oka;
	rsnh_pkg::cand_t cand_a, cand_b;
	logic            use_a, use_b;

	assign busy = 1'b0;
	assign accept = start && !busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.surface_kind <= 1'b0;
			cfg_q.line_a <= '0;
			cfg_q.line_b <= 32'sd65536;
			cfg_q.line_c <= '0;
			cfg_q.center_x <= '0;
			cfg_q.center_y <= '0;
			cfg_q.radius <= 31'd65536;
		end else if (cfg_write) begin
			unique case (rsnh_pkg::cfg_reg_t'(cfg_index))
				rsnh_pkg::REG_SURFACE_KIND: cfg_q.surface_kind <= cfg_data[0];
				rsnh_pkg::REG_LINE_A: cfg_q.line_a <= cfg_data;
				rsnh_pkg::REG_LINE_B: cfg_q.line_b <= cfg_data;
				rsnh_pkg::REG_LINE_C: cfg_q.line_c <= cfg_data;
				rsnh_pkg::REG_CENTER_X: cfg_q.center_x <= cfg_data;
				rsnh_pkg::REG_CENTER_Y: cfg_q.center_y <= cfg_data;
				rsnh_pkg::REG_RADIUS: cfg_q.radius <= cfg_data[rsnh_pkg::RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// Ray direction.
	rsnh_dir u_dir (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_x0    (start_x),
		.in_y0    (start_y),
		.in_angle (track_angle),
		.out_valid(dir_valid),
		.out_ray  (dir_ray)
	);

	// Both solvers run on every beat; the surface kind picks one at the end.
	rsnh_line #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_line (
		.clk    (clk),
		.in_ray (dir_ray),
		.cfg    (cfg_q),
		.out_t  (line_t),
		.out_ok (line_ok)
	);

	rsnh_circle u_circle (
		.clk    (clk),
		.in_ray (dir_ray),
		.cfg    (cfg_q),
		.out_t1 (circ_t1),
		.out_t2 (circ_t2),
		.out_ok (circ_ok)
	);

	// Ray and valid bits travel alongside the solvers.
	always_ff @(posedge clk) begin
		ray_dl_s1[0] <= dir_ray;
		for (int k = 1; k < SLAT; k++) begin
			ray_dl_s1[k] <= ray_dl_s1[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VLAT; k++) begin
				vld_dl_s1[k] <= 1'b0;
			end
		end else begin
			vld_dl_s1[0] <= dir_valid;
			for (int k = 1; k < VLAT; k++) begin
				vld_dl_s1[k] <= vld_dl_s1[k-1];
			end
		end
	end

	assign ta = cfg_q.surface_kind ? circ_t1 : line_t;
	assign oka = cfg_q.surface_kind ? circ_ok : line_ok;

	rsnh_place u_place_a (
		.clk     (clk),
		.in_t    (ta),
		.in_ok   (oka),
		.in_ray  (ray_dl_s1[SLAT-1]),
		.out_cand(cand_a)
	);

	rsnh_place u_place_b (
		.clk     (clk),
		.in_t    (circ_t2),
		.in_ok   (circ_ok),
		.in_ray  (ray_dl_s1[SLAT-1]),
		.out_cand(cand_b)
	);

	// Nearer candidate wins; on a tie the second one wins.
	always_comb begin
		use_a = cand_a.ok && (!cfg_q.surface_kind || !cand_b.ok || (cand_a.mag < cand_b.mag));
		use_b = cfg_q.surface_kind && cand_b.ok && !use_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_dl_s1[VLAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (use_a) begin
			hit_found <= 1'b1;
			hit_distance <= cand_a.dist_sat;
			hit_x <= cand_a.hx;
			hit_y <= cand_a.hy;
		end else if (use_b) begin
			hit_found <= 1'b1;
			hit_distance <= cand_b.dist_sat;
			hit_x <= cand_b.hx;
			hit_y <= cand_b.hy;
		end else begin
			hit_found <= 1'b0;
			hit_distance <= '1;
			hit_x <= '0;
			hit_y <= '0;
		end
	end

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(rsnh_pkg::TOTAL_LAT) done)
		else $error("command beat produced no result at the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, rsnh_pkg::TOTAL_LAT))
		else $error("result beat without a matching command beat");

	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit_found |-> (hit_distance == '1) && (hit_x == '0) && (hit_y == '0))
		else $error("miss result carries nonzero fields");
`endif

endmodule

`default_nettype wire
